>>> design/mid_pkg.sv
// Package for the MIPS-I instruction decoder: operation codes, the decoded
// result struct and the opcode/function lookup functions.
// No dependencies.
`default_nettype none
package mid_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned OP_W   = 7;
  localparam int unsigned REG_W  = 5;
  localparam int unsigned IMM_W  = 16;
  localparam int unsigned TGT_W  = 26;
  // op, src, tgt, dst, sa, imm, target packed and padded to whole bytes
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned OUT_USED_W = OP_W + 4 * REG_W + IMM_W + TGT_W;

  // primary opcode classes that need a second-level decode
  localparam logic [5:0] OPC_SPECIAL = 6'h00;
  localparam logic [5:0] OPC_REGIMM  = 6'h01;
  localparam logic [5:0] OPC_COP0    = 6'h10;
  localparam logic [5:0] OPC_COP2    = 6'h12;

  localparam logic [4:0] RS_MF   = 5'd0;
  localparam logic [4:0] RS_CF   = 5'd2;
  localparam logic [4:0] RS_MT   = 5'd4;
  localparam logic [4:0] RS_CT   = 5'd6;
  localparam logic [4:0] RS_CO   = 5'd16;
  localparam logic [5:0] FN_RFE  = 6'h10;

  localparam logic [4:0] RT_BLTZ   = 5'h00;
  localparam logic [4:0] RT_BGEZ   = 5'h01;
  localparam logic [4:0] RT_BLTZAL = 5'h10;
  localparam logic [4:0] RT_BGEZAL = 5'h11;

  typedef enum logic [OP_W-1:0] {
    OP_RESERVED = 7'd0,
    OP_MFC0 = 7'd1, OP_MTC0, OP_RFE, OP_MFC2, OP_CFC2, OP_MTC2, OP_CTC2,
    OP_RTPS, OP_NCLIP, OP_DPCS, OP_INTPL, OP_MVMVA, OP_NCDS, OP_CDP, OP_NCDT,
    OP_NCCS, OP_CC, OP_NCS, OP_NCT, OP_DCPL, OP_DPCT, OP_AVSZ3, OP_AVSZ4,
    OP_RTPT, OP_NCCT,
    OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU,
    OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LB, OP_LH,
    OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR, OP_LWU, OP_SB, OP_SH, OP_SWL,
    OP_SW, OP_SWR,
    OP_BLTZ, OP_BGEZ, OP_BLTZAL, OP_BGEZAL,
    OP_SLL, OP_SRL, OP_SRA, OP_SLLV, OP_SRLV, OP_SRAV, OP_JR, OP_JALR,
    OP_SYSCALL, OP_BREAK, OP_MFHI, OP_MTHI, OP_MFLO, OP_MTLO, OP_MULT,
    OP_MULTU, OP_DIV, OP_DIVU, OP_ADD, OP_ADDU, OP_SUB, OP_SUBU, OP_AND,
    OP_OR, OP_XOR, OP_NOR, OP_SLT, OP_SLTU,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             rsvd;
    logic [REG_W-1:0] src;
    logic [REG_W-1:0] tgt;
    logic [REG_W-1:0] dst;
    logic [REG_W-1:0] sa;
    logic [IMM_W-1:0] imm;
    logic [TGT_W-1:0] target;
  } decode_t;

  function automatic op_t primary_op(input logic [5:0] opc);
    op_t r;
    case (opc)
      6'h02: r = OP_J;     6'h03: r = OP_JAL;   6'h04: r = OP_BEQ;
      6'h05: r = OP_BNE;   6'h06: r = OP_BLEZ;  6'h07: r = OP_BGTZ;
      6'h08: r = OP_ADDI;  6'h09: r = OP_ADDIU; 6'h0A: r = OP_SLTI;
      6'h0B: r = OP_SLTIU; 6'h0C: r = OP_ANDI;  6'h0D: r = OP_ORI;
      6'h0E: r = OP_XORI;  6'h0F: r = OP_LUI;
      6'h20: r = OP_LB;    6'h21: r = OP_LH;    6'h22: r = OP_LWL;
      6'h23: r = OP_LW;    6'h24: r = OP_LBU;   6'h25: r = OP_LHU;
      6'h26: r = OP_LWR;   6'h27: r = OP_LWU;   6'h28: r = OP_SB;
      6'h29: r = OP_SH;    6'h2A: r = OP_SWL;   6'h2B: r = OP_SW;
      6'h2E: r = OP_SWR;
      default: r = OP_RESERVED;
    endcase
    return r;
  endfunction

  function automatic op_t special_op(input logic [5:0] fn);
    op_t r;
    case (fn)
      6'h00: r = OP_SLL;   6'h02: r = OP_SRL;   6'h03: r = OP_SRA;
      6'h04: r = OP_SLLV;  6'h06: r = OP_SRLV;  6'h07: r = OP_SRAV;
      6'h08: r = OP_JR;    6'h09: r = OP_JALR;  6'h0C: r = OP_SYSCALL;
      6'h0D: r = OP_BREAK; 6'h10: r = OP_MFHI;  6'h11: r = OP_MTHI;
      6'h12: r = OP_MFLO;  6'h13: r = OP_MTLO;  6'h18: r = OP_MULT;
      6'h19: r = OP_MULTU; 6'h1A: r = OP_DIV;   6'h1B: r = OP_DIVU;
      6'h20: r = OP_ADD;   6'h21: r = OP_ADDU;  6'h22: r = OP_SUB;
      6'h23: r = OP_SUBU;  6'h24: r = OP_AND;   6'h25: r = OP_OR;
      6'h26: r = OP_XOR;   6'h27: r = OP_NOR;   6'h2A: r = OP_SLT;
      6'h2B: r = OP_SLTU;
      default: r = OP_RESERVED;
    endcase
    return r;
  endfunction

  // geometry coprocessor commands; several aliases map onto rtps
  function automatic op_t gte_op(input logic [5:0] fn);
    op_t r;
    case (fn)
      6'h01, 6'h0C, 6'h28, 6'h3D, 6'h3E: r = OP_RTPS;
      6'h06: r = OP_NCLIP; 6'h10: r = OP_DPCS;  6'h11: r = OP_INTPL;
      6'h12: r = OP_MVMVA; 6'h13: r = OP_NCDS;  6'h14: r = OP_CDP;
      6'h16: r = OP_NCDT;  6'h1B: r = OP_NCCS;  6'h1C: r = OP_CC;
      6'h1E: r = OP_NCS;   6'h20: r = OP_NCT;   6'h29: r = OP_DCPL;
      6'h2A: r = OP_DPCT;  6'h2D: r = OP_AVSZ3; 6'h2E: r = OP_AVSZ4;
      6'h30: r = OP_RTPT;  6'h3F: r = OP_NCCT;
      default: r = OP_RESERVED;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/mid_decode.sv
// Combinational decode of one instruction word into operation and fields.
// Depends on mid_pkg.
`default_nettype none
module mid_decode
  import mid_pkg::*;
(
  input  wire logic [WORD_W-1:0] word,
  output decode_t                dec
);

  logic [5:0] opc;
  logic [4:0] rs;
  logic [4:0] rt;
  logic [5:0] fn;
  op_t        op;

  assign opc = word[31:26];
  assign rs  = word[25:21];
  assign rt  = word[20:16];
  assign fn  = word[5:0];

  always_comb begin
    case (opc)
      OPC_SPECIAL: op = special_op(fn);
      OPC_REGIMM: begin
        case (rt)
          RT_BLTZ:   op = OP_BLTZ;
          RT_BGEZ:   op = OP_BGEZ;
          RT_BLTZAL: op = OP_BLTZAL;
          RT_BGEZAL: op = OP_BGEZAL;
          default:   op = OP_RESERVED;
        endcase
      end
      OPC_COP0: begin
        if (rs == RS_MF)                       op = OP_MFC0;
        else if (rs == RS_MT)                  op = OP_MTC0;
        else if (rs == RS_CO && fn == FN_RFE)  op = OP_RFE;
        else                                   op = OP_RESERVED;
      end
      OPC_COP2: begin
        case (rs)
          RS_MF: op = OP_MFC2;
          RS_CF: op = OP_CFC2;
          RS_MT: op = OP_MTC2;
          RS_CT: op = OP_CTC2;
          default: begin
            // command words need bit 25; others are a silent no-op
            if (!word[25]) op = OP_NOP;
            else           op = gte_op(fn);
          end
        endcase
      end
      default: op = primary_op(opc);
    endcase
  end

  always_comb begin
    dec.op     = op;
    dec.rsvd   = (op == OP_RESERVED);
    dec.src    = word[25:21];
    dec.tgt    = word[20:16];
    dec.dst    = word[15:11];
    dec.sa     = word[10:6];
    dec.imm    = word[15:0];
    dec.target = word[25:0];
  end

endmodule
`default_nettype wire

>>> design/mips1_instruction_decoder.sv
// Top level of the MIPS-I instruction decoder: input register, decode logic
// and result register. Depends on mid_pkg and mid_decode.
//
// Usage:
//   Input channel in_*: one 32-bit instruction word per transfer on in_tdata.
//   Result channel out_*: the operation code and extracted fields on
//   out_tdata, the reserved-instruction flag on out_tuser.
//   On acceptance the word lands in the input register; the decode logic
//   then writes the result register once it is free, and out_tvalid rises.
//   Throughput is one word per cycle while out_tready stays high; a new
//   word is taken while an older one is still in flight.
//   When the receiver stalls (out_tready low with out_tvalid high) the result
//   register holds; the input register fills and then in_tready drops, so
//   no word is lost or repeated. in_tready follows out_tready through
//   the two stage valids combinationally.
//   Reset (rst_n low, synchronous) empties both stages; no word is pending
//   afterwards and the block needs no warm-up.
//   The block has no state between words: each result depends only on its
//   own instruction word.
`default_nettype none
module mips1_instruction_decoder
  import mid_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [WORD_W-1:0]     in_tdata,   // [31:0] instr_word
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [6:0] op_code, [11:7] src_reg, [16:12] tgt_reg, [21:17] dst_reg,
  // [26:22] shift_amount, [42:27] imm_half, [68:43] jump_target, rest zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tuser   // [0] reserved_flag
);

  logic              in_vld_r;
  logic [WORD_W-1:0] word_r;
  logic              out_vld_r;
  decode_t           res_r;
  decode_t           dec;
  logic              out_free;
  logic              in_free;

  assign out_free  = !out_vld_r || out_tready;
  assign in_free   = !in_vld_r || out_free;
  assign in_tready = in_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_free) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && in_tvalid) begin
      word_r <= in_tdata;
    end
  end

  mid_decode u_decode (
    .word (word_r),
    .dec  (dec)
  );

  // advance the result register whenever it is empty or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_vld_r) begin
      res_r <= dec;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = res_r.rsvd;
  assign out_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}},
                       res_r.target, res_r.imm, res_r.sa, res_r.dst,
                       res_r.tgt, res_r.src, res_r.op};

endmodule
`default_nettype wire
